// File: hdl/aipa_pkg.sv
// Shared types and constants for the axis interlock priority arbiter.
// Flag bit positions, interlock and stop mode codes, and the result struct.
`timescale 1ns / 1ps

package aipa_pkg;

  localparam int unsigned FlagWidth = 24;

  // Raw interlock flag bit positions
  localparam int unsigned FBothLim  = 0;
  localparam int unsigned FDrvHl    = 1;
  localparam int unsigned FDrvLag   = 2;
  localparam int unsigned FDrvMaxV  = 3;
  localparam int unsigned FDrvVDiff = 4;
  localparam int unsigned FHw       = 5;
  localparam int unsigned FMaster   = 6;
  localparam int unsigned FAnalog   = 7;
  localparam int unsigned FStall    = 8;
  localparam int unsigned FAxErr    = 9;
  localparam int unsigned FBwdHard  = 10;
  localparam int unsigned FBwdSoft  = 11;
  localparam int unsigned FFwdHard  = 12;
  localparam int unsigned FFwdSoft  = 13;
  localparam int unsigned FTrjHl    = 14;
  localparam int unsigned FTrjLag   = 15;
  localparam int unsigned FTrjMaxV  = 16;
  localparam int unsigned FTrjVDiff = 17;
  localparam int unsigned FPlc      = 18;
  localparam int unsigned FPlcBwd   = 19;
  localparam int unsigned FPlcFwd   = 20;
  localparam int unsigned FEncDiff  = 21;
  localparam int unsigned FSafety   = 22;
  localparam int unsigned FNoExec   = 23;

  typedef enum logic [4:0] {
    CODE_NONE      = 5'd0,
    CODE_SOFT_BWD  = 5'd1,
    CODE_SOFT_FWD  = 5'd2,
    CODE_HARD_BWD  = 5'd3,
    CODE_HARD_FWD  = 5'd4,
    CODE_NO_EXEC   = 5'd5,
    CODE_LAG       = 5'd6,
    CODE_BOTH_LIM  = 5'd7,
    CODE_EXTERNAL  = 5'd8,
    CODE_TRANSFORM = 5'd9,
    CODE_MAX_SPEED = 5'd10,
    CODE_CTRL_HIGH = 5'd11,
    CODE_CTRL_INC  = 5'd12,
    CODE_AXIS_ERR  = 5'd13,
    CODE_UNEXP_LIM = 5'd14,
    CODE_VEL_DIFF  = 5'd15,
    CODE_MASTER    = 5'd16,
    CODE_PLC       = 5'd17,
    CODE_PLC_BWD   = 5'd18,
    CODE_PLC_FWD   = 5'd19,
    CODE_ENC_DIFF  = 5'd20,
    CODE_ANALOG    = 5'd21,
    CODE_SAFETY    = 5'd22,
    CODE_STALL     = 5'd23
  } code_e;

  typedef enum logic [1:0] {
    MODE_RUN    = 2'd0,
    MODE_NORMAL = 2'd1,
    MODE_EMERG  = 2'd2
  } mode_e;

  typedef struct packed {
    code_e code;
    mode_e mode;
    code_e motion;
    logic  drive;
    logic  bwd_s;
    logic  fwd_s;
    logic  bwd_r;
    logic  fwd_r;
  } arb_res_t;

endpackage

// File: hdl/aipa_arbiter.sv
// Combinational interlock arbitration: summaries, priority chain, stop mode
// and direction-aware motion interlock. Depends on aipa_pkg.
`timescale 1ns / 1ps

module aipa_arbiter (
  input  logic [aipa_pkg::FlagWidth-1:0] flags_i,
  input  logic                           mbwd_i,
  input  logic                           mfwd_i,
  output aipa_pkg::arb_res_t             res_o
);
  import aipa_pkg::*;

  logic [FlagWidth-1:0] f;
  code_e emerg;
  code_e code;
  mode_e mode;
  code_e motion;
  logic  drive, bwd_r, fwd_r, common_r;
  logic  bwd_only, fwd_only;

  assign f = flags_i;

  always_comb begin
    if (f[FSafety])                      emerg = CODE_SAFETY;
    else if (f[FBothLim])                emerg = CODE_BOTH_LIM;
    else if (f[FDrvVDiff] || f[FTrjVDiff]) emerg = CODE_VEL_DIFF;
    else if (f[FDrvHl] || f[FTrjHl])     emerg = CODE_CTRL_HIGH;
    else if (f[FMaster])                 emerg = CODE_MASTER;
    else if (f[FHw])                     emerg = CODE_EXTERNAL;
    else if (f[FDrvLag] || f[FTrjLag])   emerg = CODE_LAG;
    else if (f[FAnalog])                 emerg = CODE_ANALOG;
    else if (f[FStall])                  emerg = CODE_STALL;
    else                                 emerg = CODE_NONE;
  end

  always_comb begin
    mode = MODE_NORMAL;
    if (f == '0) begin
      code = CODE_NONE;
      mode = MODE_RUN;
    end else if (emerg != CODE_NONE) begin
      code = emerg;
      mode = MODE_EMERG;
    end else if (f[FBwdHard])                code = CODE_HARD_BWD;
    else if (f[FFwdHard])                    code = CODE_HARD_FWD;
    else if (f[FBwdSoft])                    code = CODE_SOFT_BWD;
    else if (f[FFwdSoft])                    code = CODE_SOFT_FWD;
    else if (f[FDrvMaxV] || f[FTrjMaxV])     code = CODE_MAX_SPEED;
    else if (f[FNoExec])                     code = CODE_NO_EXEC;
    else if (f[FPlc])                        code = CODE_PLC;
    else if (f[FPlcBwd])                     code = CODE_PLC_BWD;
    else if (f[FPlcFwd])                     code = CODE_PLC_FWD;
    else if (f[FEncDiff])                    code = CODE_ENC_DIFF;
    else if (f[FAxErr]) begin
      code = CODE_AXIS_ERR;
      mode = MODE_EMERG;
    end else begin
      // not reached: every flag bit maps to a code
      code = CODE_NONE;
      mode = MODE_RUN;
    end
  end

  assign bwd_only = mbwd_i && !mfwd_i;
  assign fwd_only = mfwd_i && !mbwd_i;

  always_comb begin
    if (code == CODE_NONE || code == CODE_NO_EXEC)   motion = code;
    else if (emerg != CODE_NONE)                     motion = emerg;
    else if (!bwd_only && !fwd_only)                 motion = code;  // direction unclear
    else if (bwd_only && f[FBwdHard])                motion = CODE_HARD_BWD;
    else if (bwd_only && f[FBwdSoft])                motion = CODE_SOFT_BWD;
    else if (fwd_only && f[FFwdHard])                motion = CODE_HARD_FWD;
    else if (fwd_only && f[FFwdSoft])                motion = CODE_SOFT_FWD;
    else if (f[FDrvMaxV] || f[FTrjMaxV])             motion = CODE_MAX_SPEED;
    else if (f[FPlc])                                motion = CODE_PLC;
    else if (bwd_only && f[FPlcBwd])                 motion = CODE_PLC_BWD;
    else if (fwd_only && f[FPlcFwd])                 motion = CODE_PLC_FWD;
    else if (f[FEncDiff])                            motion = CODE_ENC_DIFF;
    else if (f[FAxErr])                              motion = CODE_AXIS_ERR;
    else                                             motion = CODE_NONE;
  end

  assign drive    = |f[FStall:FBothLim];
  assign common_r = drive || f[FAxErr] || f[FTrjHl] || f[FTrjLag] || f[FTrjMaxV]
                    || f[FTrjVDiff] || f[FPlc] || f[FEncDiff] || f[FSafety];
  assign bwd_r    = common_r || f[FBwdHard] || f[FBwdSoft] || f[FPlcBwd];
  assign fwd_r    = common_r || f[FFwdHard] || f[FFwdSoft] || f[FPlcFwd];

  always_comb begin
    res_o.code   = code;
    res_o.mode   = mode;
    res_o.motion = motion;
    res_o.drive  = drive;
    res_o.bwd_r  = bwd_r;
    res_o.fwd_r  = fwd_r;
    res_o.bwd_s  = bwd_r || f[FNoExec];
    res_o.fwd_s  = fwd_r || f[FNoExec];
  end

endmodule

// File: hdl/axis_interlock_priority_arbiter_unit.sv
// Top level of the axis interlock priority arbiter: input register, state
// (previous setpoint, previous code, latch) and result register.
// Depends on aipa_pkg and aipa_arbiter.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i / in_ready_o) carries one control-cycle sample:
//   raw interlock flags, command class, trajectory source, target position,
//   position setpoint, velocity setpoint and a latch clear request.
//   Output channel (out_valid_o / out_ready_i) carries one result per sample:
//   active interlock code, stop mode, latched code, summaries, change flag.
// Path: an accepted transaction is held in the input register, then moves
//   into the result register, which drives the output ports.
// Throughput: one transaction per cycle while out_ready_i is high; the
//   arbitration is a single pass of shallow logic between the registers.
// Reset: clears both valid bits, the previous setpoint, the previous code and
//   the latch (all to zero / none).
// Stall: while out_ready_i is low the result holds; one more transaction is
//   taken into the input register, then in_ready_o drops until the result
//   drains. State advances only when a sample moves into the result register.

module axis_interlock_priority_arbiter_unit #(
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [aipa_pkg::FlagWidth-1:0]    interlock_flags_i,
  input  logic                              velocity_command_i,
  input  logic                              external_trajectory_i,
  input  logic signed [POSITION_WIDTH-1:0]  target_position_i,
  input  logic signed [POSITION_WIDTH-1:0]  position_setpoint_i,
  input  logic signed [31:0]                velocity_setpoint_i,
  input  logic                              clear_latch_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [4:0]                        interlock_code_o,
  output logic [1:0]                        stop_mode_o,
  output logic [4:0]                        latched_code_o,
  output logic                              drive_summary_o,
  output logic                              bwd_summary_o,
  output logic                              fwd_summary_o,
  output logic                              bwd_summary_reported_o,
  output logic                              fwd_summary_reported_o,
  output logic                              code_changed_o
);
  import aipa_pkg::*;

  // input register
  logic                             in_valid_q;
  logic [FlagWidth-1:0]             flags_q;
  logic                             velcmd_q;
  logic signed [POSITION_WIDTH-1:0] tgt_q;
  logic signed [POSITION_WIDTH-1:0] sp_q;
  logic signed [31:0]               vel_q;
  logic                             clr_q;

  // state
  logic signed [POSITION_WIDTH-1:0] prev_sp_q;
  code_e                            prev_code_q;
  code_e                            latch_q, latch_d;

  // result register
  logic     out_valid_q;
  arb_res_t res_q;
  logic     changed_q;

  logic     advance;
  logic     vneg, vpos, mbwd, mfwd;
  code_e    latch_base;
  arb_res_t res;
  arb_res_t res_out;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  assign vneg = vel_q[31];
  assign vpos = (vel_q != '0) && !vel_q[31];
  assign mbwd = (tgt_q < sp_q) || (sp_q < prev_sp_q) || (velcmd_q && vneg);
  assign mfwd = (tgt_q > sp_q) || (sp_q > prev_sp_q) || (velcmd_q && vpos);

  aipa_arbiter u_arbiter (
    .flags_i (flags_q),
    .mbwd_i  (mbwd),
    .mfwd_i  (mfwd),
    .res_o   (res)
  );

  always_comb begin
    latch_base = clr_q ? CODE_NONE : latch_q;
    latch_d    = latch_base;
    if (res.code != CODE_NONE && res.code != CODE_NO_EXEC && latch_base == CODE_NONE &&
        res.motion != CODE_NONE && res.motion != CODE_NO_EXEC) begin
      latch_d = res.motion;
    end
  end

  // result carries the latch after this step
  always_comb begin
    res_out        = res;
    res_out.motion = latch_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      prev_sp_q   <= '0;
      prev_code_q <= CODE_NONE;
      latch_q     <= CODE_NONE;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        prev_sp_q   <= sp_q;
        prev_code_q <= res.code;
        latch_q     <= latch_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      flags_q  <= interlock_flags_i;
      velcmd_q <= velocity_command_i || external_trajectory_i;
      tgt_q    <= target_position_i;
      sp_q     <= position_setpoint_i;
      vel_q    <= velocity_setpoint_i;
      clr_q    <= clear_latch_i;
    end
    if (advance) begin
      res_q     <= res_out;
      changed_q <= (res.code != prev_code_q);
    end
  end

  assign out_valid_o            = out_valid_q;
  assign interlock_code_o       = res_q.code;
  assign stop_mode_o            = res_q.mode;
  assign latched_code_o         = res_q.motion;
  assign drive_summary_o        = res_q.drive;
  assign bwd_summary_o          = res_q.bwd_s;
  assign fwd_summary_o          = res_q.fwd_s;
  assign bwd_summary_reported_o = res_q.bwd_r;
  assign fwd_summary_reported_o = res_q.fwd_r;
  assign code_changed_o         = changed_q;

endmodule

// File: hdl/aipa_checker.sv
// Port-level checks for the axis interlock priority arbiter, and the bind
// that attaches them to the top level. Depends on aipa_pkg.
`timescale 1ns / 1ps

module aipa_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [4:0] interlock_code_o,
  input logic [1:0] stop_mode_o,
  input logic [4:0] latched_code_o,
  input logic       bwd_summary_o,
  input logic       bwd_summary_reported_o
);
  import aipa_pkg::*;

  // no interlock exactly when the axis may run
  a_run_iff_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((interlock_code_o == CODE_NONE) == (stop_mode_o == MODE_RUN)))
    else $error("stop mode disagrees with interlock code");

  a_no_reserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (interlock_code_o != CODE_TRANSFORM && interlock_code_o != CODE_CTRL_INC
                     && interlock_code_o != CODE_UNEXP_LIM && interlock_code_o <= CODE_STALL
                     && stop_mode_o <= MODE_EMERG))
    else $error("reserved interlock code or stop mode");

  // no-execute is never latched
  a_latch_no_noexec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (latched_code_o != CODE_NO_EXEC && latched_code_o <= CODE_STALL))
    else $error("invalid latched code");

  a_summary_superset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bwd_summary_reported_o) |-> bwd_summary_o)
    else $error("reported summary set without summary");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(interlock_code_o) && $stable(latched_code_o)))
    else $error("result changed while stalled");

endmodule

bind axis_interlock_priority_arbiter_unit aipa_checker u_aipa_checker (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .out_valid_o            (out_valid_o),
  .out_ready_i            (out_ready_i),
  .interlock_code_o       (interlock_code_o),
  .stop_mode_o            (stop_mode_o),
  .latched_code_o         (latched_code_o),
  .bwd_summary_o          (bwd_summary_o),
  .bwd_summary_reported_o (bwd_summary_reported_o)
);

// File: dv/tb.sv
// Testbench for axis_interlock_priority_arbiter_unit: directed priority, direction and
// latch tests, then random motion sequences, checked against an in-bench predictor.
// Depends on aipa_pkg and the arbiter RTL.
`timescale 1ns / 1ps

module tb;
  import aipa_pkg::*;

  localparam int unsigned PosWidth   = 32;
  localparam int          CycleLimit = 200000;
  localparam int          NumRandom  = 1320;

  // Flag bits from highest to lowest arbitration priority
  localparam int unsigned PrioBits[24] = '{
    FSafety, FBothLim, FDrvVDiff, FTrjVDiff, FDrvHl, FTrjHl, FMaster, FHw,
    FDrvLag, FTrjLag, FAnalog, FStall, FBwdHard, FFwdHard, FBwdSoft, FFwdSoft,
    FDrvMaxV, FTrjMaxV, FNoExec, FPlc, FPlcBwd, FPlcFwd, FEncDiff, FAxErr
  };

  typedef struct {
    logic [FlagWidth-1:0] flags;
    logic                 vel_cmd;
    logic                 ext_traj;
    logic signed [31:0]   target;
    logic signed [31:0]   setpoint;
    logic signed [31:0]   velocity;
    logic                 clear;
  } sample_t;

  typedef struct {
    code_e code;
    mode_e mode;
    code_e latched;
    logic  drive;
    logic  bwd_s;
    logic  fwd_s;
    logic  bwd_r;
    logic  fwd_r;
    logic  changed;
  } arb_out_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic [FlagWidth-1:0]        interlock_flags_i = '0;
  logic                        velocity_command_i = 1'b0;
  logic                        external_trajectory_i = 1'b0;
  logic signed [PosWidth-1:0]  target_position_i = '0;
  logic signed [PosWidth-1:0]  position_setpoint_i = '0;
  logic signed [31:0]          velocity_setpoint_i = '0;
  logic                        clear_latch_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [4:0]                  interlock_code_o;
  logic [1:0]                  stop_mode_o;
  logic [4:0]                  latched_code_o;
  logic                        drive_summary_o;
  logic                        bwd_summary_o;
  logic                        fwd_summary_o;
  logic                        bwd_summary_reported_o;
  logic                        fwd_summary_reported_o;
  logic                        code_changed_o;

  axis_interlock_priority_arbiter_unit #(
    .POSITION_WIDTH(PosWidth)
  ) dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .interlock_flags_i      (interlock_flags_i),
    .velocity_command_i     (velocity_command_i),
    .external_trajectory_i  (external_trajectory_i),
    .target_position_i      (target_position_i),
    .position_setpoint_i    (position_setpoint_i),
    .velocity_setpoint_i    (velocity_setpoint_i),
    .clear_latch_i          (clear_latch_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .interlock_code_o       (interlock_code_o),
    .stop_mode_o            (stop_mode_o),
    .latched_code_o         (latched_code_o),
    .drive_summary_o        (drive_summary_o),
    .bwd_summary_o          (bwd_summary_o),
    .fwd_summary_o          (fwd_summary_o),
    .bwd_summary_reported_o (bwd_summary_reported_o),
    .fwd_summary_reported_o (fwd_summary_reported_o),
    .code_changed_o         (code_changed_o)
  );

  // Predictor state
  logic signed [31:0] prev_setpoint = '0;
  code_e              prev_code = CODE_NONE;
  code_e              latch_code = CODE_NONE;

  arb_out_t           arb_out_q[$];
  int                 err_cnt = 0;
  int                 result_cnt = 0;
  int                 cycle_cnt = 0;
  bit                 tx_quiet = 1'b0;
  bit                 rx_quiet = 1'b0;

  // Random trajectory for the well-formed stimulus
  logic signed [31:0] traj_target = '0;
  logic signed [31:0] traj_sp = '0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic code_e emergency_cause(logic [FlagWidth-1:0] f);
    if (f[FSafety]) return CODE_SAFETY;
    if (f[FBothLim]) return CODE_BOTH_LIM;
    if (f[FDrvVDiff] || f[FTrjVDiff]) return CODE_VEL_DIFF;
    if (f[FDrvHl] || f[FTrjHl]) return CODE_CTRL_HIGH;
    if (f[FMaster]) return CODE_MASTER;
    if (f[FHw]) return CODE_EXTERNAL;
    if (f[FDrvLag] || f[FTrjLag]) return CODE_LAG;
    if (f[FAnalog]) return CODE_ANALOG;
    if (f[FStall]) return CODE_STALL;
    return CODE_NONE;
  endfunction

  function automatic code_e active_interlock(logic [FlagWidth-1:0] f, output mode_e m);
    code_e c;
    c = emergency_cause(f);
    m = MODE_NORMAL;
    if (f == '0) begin
      m = MODE_RUN;
      return CODE_NONE;
    end
    if (c != CODE_NONE) begin
      m = MODE_EMERG;
      return c;
    end
    if (f[FBwdHard]) return CODE_HARD_BWD;
    if (f[FFwdHard]) return CODE_HARD_FWD;
    if (f[FBwdSoft]) return CODE_SOFT_BWD;
    if (f[FFwdSoft]) return CODE_SOFT_FWD;
    if (f[FDrvMaxV] || f[FTrjMaxV]) return CODE_MAX_SPEED;
    if (f[FNoExec]) return CODE_NO_EXEC;
    if (f[FPlc]) return CODE_PLC;
    if (f[FPlcBwd]) return CODE_PLC_BWD;
    if (f[FPlcFwd]) return CODE_PLC_FWD;
    if (f[FEncDiff]) return CODE_ENC_DIFF;
    if (f[FAxErr]) begin
      m = MODE_EMERG;
      return CODE_AXIS_ERR;
    end
    m = MODE_RUN;
    return CODE_NONE;
  endfunction

  // Interlock that matters for the current direction of motion
  function automatic code_e directional_interlock(logic [FlagWidth-1:0] f, code_e code,
                                                  logic bwd, logic fwd);
    code_e c;
    c = emergency_cause(f);
    if (code == CODE_NONE || code == CODE_NO_EXEC) return code;
    if (c != CODE_NONE) return c;
    if (bwd && !fwd) begin
      if (f[FBwdHard]) return CODE_HARD_BWD;
      if (f[FBwdSoft]) return CODE_SOFT_BWD;
    end else if (fwd && !bwd) begin
      if (f[FFwdHard]) return CODE_HARD_FWD;
      if (f[FFwdSoft]) return CODE_SOFT_FWD;
    end else begin
      return code;  // no clear direction
    end
    if (f[FDrvMaxV] || f[FTrjMaxV]) return CODE_MAX_SPEED;
    if (f[FPlc]) return CODE_PLC;
    if (bwd && !fwd && f[FPlcBwd]) return CODE_PLC_BWD;
    if (fwd && !bwd && f[FPlcFwd]) return CODE_PLC_FWD;
    if (f[FEncDiff]) return CODE_ENC_DIFF;
    if (f[FAxErr]) return CODE_AXIS_ERR;
    return CODE_NONE;
  endfunction

  function automatic arb_out_t arbitrate_sample(sample_t s);
    arb_out_t r;
    logic     vel_mode;
    logic     vneg;
    logic     vpos;
    logic     mbwd;
    logic     mfwd;
    code_e    dir_code;
    logic [FlagWidth-1:0] f;
    f = s.flags;
    vel_mode = s.vel_cmd | s.ext_traj;
    vneg = s.velocity[31];
    vpos = (s.velocity != 0) && !s.velocity[31];
    if (s.clear) latch_code = CODE_NONE;

    r.drive = |f[FStall:FBothLim];
    r.bwd_r = r.drive | f[FAxErr] | f[FBwdHard] | f[FBwdSoft] | f[FTrjHl] | f[FTrjLag] |
              f[FTrjMaxV] | f[FTrjVDiff] | f[FPlc] | f[FPlcBwd] | f[FEncDiff] | f[FSafety];
    r.fwd_r = r.drive | f[FAxErr] | f[FFwdHard] | f[FFwdSoft] | f[FTrjHl] | f[FTrjLag] |
              f[FTrjMaxV] | f[FTrjVDiff] | f[FPlc] | f[FPlcFwd] | f[FEncDiff] | f[FSafety];
    r.bwd_s = r.bwd_r | f[FNoExec];
    r.fwd_s = r.fwd_r | f[FNoExec];

    r.code = active_interlock(f, r.mode);

    mbwd = (s.target < s.setpoint) || (s.setpoint < prev_setpoint) || (vel_mode && vneg);
    mfwd = (s.target > s.setpoint) || (s.setpoint > prev_setpoint) || (vel_mode && vpos);

    if (r.code != CODE_NONE && r.code != CODE_NO_EXEC && latch_code == CODE_NONE) begin
      dir_code = directional_interlock(f, r.code, mbwd, mfwd);
      if (dir_code != CODE_NONE && dir_code != CODE_NO_EXEC) latch_code = dir_code;
    end

    r.latched = latch_code;
    r.changed = (r.code != prev_code);
    prev_code = r.code;
    prev_setpoint = s.setpoint;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------

  function automatic sample_t mk_sample(logic [FlagWidth-1:0] flags, logic vc, logic ext,
                                        logic signed [31:0] tgt, logic signed [31:0] sp,
                                        logic signed [31:0] vel, logic clr);
    sample_t s;
    s.flags = flags;
    s.vel_cmd = vc;
    s.ext_traj = ext;
    s.target = tgt;
    s.setpoint = sp;
    s.velocity = vel;
    s.clear = clr;
    return s;
  endfunction

  // Called right after a rising edge; returns at the edge that took the transaction.
  task automatic send_sample(sample_t s);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i            <= 1'b1;
    interlock_flags_i     <= s.flags;
    velocity_command_i    <= s.vel_cmd;
    external_trajectory_i <= s.ext_traj;
    target_position_i     <= s.target;
    position_setpoint_i   <= s.setpoint;
    velocity_setpoint_i   <= s.velocity;
    clear_latch_i         <= s.clear;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    arb_out_q.push_back(arbitrate_sample(s));
  endtask

  // Hold off the sender until every expected result has drained
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (arb_out_q.size() != 0);
  endtask

  task automatic report_mismatch(string field, int got, int want);
    if (err_cnt < 200)
      $display("[%0t] result %0d: %s = %0d, expected %0d", $time, result_cnt, field, got,
               want);
    err_cnt++;
  endtask

  task automatic check_result();
    arb_out_t e;
    if (arb_out_q.size() == 0) begin
      report_mismatch("unexpected transaction, interlock_code", int'(interlock_code_o), -1);
    end else begin
      e = arb_out_q.pop_front();
      if (interlock_code_o !== e.code)
        report_mismatch("interlock_code", int'(interlock_code_o), int'(e.code));
      if (stop_mode_o !== e.mode)
        report_mismatch("stop_mode", int'(stop_mode_o), int'(e.mode));
      if (latched_code_o !== e.latched)
        report_mismatch("latched_code", int'(latched_code_o), int'(e.latched));
      if (drive_summary_o !== e.drive)
        report_mismatch("drive_summary", int'(drive_summary_o), int'(e.drive));
      if (bwd_summary_o !== e.bwd_s)
        report_mismatch("bwd_summary", int'(bwd_summary_o), int'(e.bwd_s));
      if (fwd_summary_o !== e.fwd_s)
        report_mismatch("fwd_summary", int'(fwd_summary_o), int'(e.fwd_s));
      if (bwd_summary_reported_o !== e.bwd_r)
        report_mismatch("bwd_summary_reported", int'(bwd_summary_reported_o),
                        int'(e.bwd_r));
      if (fwd_summary_reported_o !== e.fwd_r)
        report_mismatch("fwd_summary_reported", int'(fwd_summary_reported_o),
                        int'(e.fwd_r));
      if (code_changed_o !== e.changed)
        report_mismatch("code_changed", int'(code_changed_o), int'(e.changed));
    end
    result_cnt++;
  endtask

  // Result side: random back-pressure per transaction, outputs sampled pre-edge
  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      check_result();
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic logic [FlagWidth-1:0] sparse_flags();
    logic [FlagWidth-1:0] f;
    int                   n;
    f = '0;
    n = $urandom_range(0, 5);
    if (n > 3) n = 0;
    for (int k = 0; k < n; k++) f[$urandom_range(0, FlagWidth - 1)] = 1'b1;
    return f;
  endfunction

  // Setpoint walks toward a target that moves now and then, like a real axis
  function automatic sample_t motion_sample();
    sample_t s;
    longint  diff;
    longint  step;
    int      pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) traj_target = 32'sh7fffffff;
    else if (pick == 1) traj_target = 32'sh80000000;
    else if (pick < 5) traj_target = $urandom;
    if ($urandom_range(0, 15) == 0) traj_sp = $urandom;
    diff = longint'(traj_target) - longint'(traj_sp);
    step = longint'($urandom_range(0, 1 << 20));
    if (diff > step) traj_sp = 32'(longint'(traj_sp) + step);
    else if (diff < -step) traj_sp = 32'(longint'(traj_sp) - step);
    else traj_sp = traj_target;
    s.flags = sparse_flags();
    s.vel_cmd = ($urandom_range(0, 3) == 0);
    s.ext_traj = ($urandom_range(0, 4) == 0);
    s.target = traj_target;
    s.setpoint = traj_sp;
    if ($urandom_range(0, 5) == 0) s.velocity = $urandom;
    else if (diff > 0) s.velocity = $urandom_range(1, 32'h7fffffff);
    else if (diff < 0) s.velocity = -$signed({1'b0, 31'($urandom_range(1, 32'h7fffffff))});
    else s.velocity = '0;
    s.clear = ($urandom_range(0, 7) == 0);
    return s;
  endfunction

  function automatic sample_t noise_sample();
    return mk_sample(24'($urandom), 1'($urandom), 1'($urandom), $urandom, $urandom,
                     $urandom, 1'($urandom));
  endfunction

  // Direction decoding and the latch: set, hold, clear, ambiguous direction
  task automatic test_direction_latch();
    send_sample(mk_sample('0, 1'b0, 1'b0, '0, '0, '0, 1'b0));
    // forward by target, soft limits on both sides: active soft bwd, latch soft fwd
    send_sample(mk_sample(24'((1 << FBwdSoft) | (1 << FFwdSoft)), 1'b0, 1'b0,
                          32'sh7fffffff, '0, '0, 1'b0));
    // latch is held while a new interlock shows up
    send_sample(mk_sample(24'(1 << FSafety), 1'b0, 1'b0, '0, '0, '0, 1'b0));
    // target below setpoint but setpoint rose: ambiguous, latch takes active code
    send_sample(mk_sample(24'(1 << FPlcBwd), 1'b0, 1'b0, 32'sh80000000, 32'sh7fffffff, '0,
                          1'b1));
    // backward by velocity only, plc fwd is irrelevant: nothing latched after clear
    send_sample(mk_sample(24'(1 << FPlcFwd), 1'b1, 1'b0, 32'sh7fffffff, 32'sh7fffffff,
                          32'sh80000000, 1'b1));
    send_sample(mk_sample(24'(1 << FNoExec), 1'b0, 1'b0, 32'sh7fffffff, 32'sh7fffffff, '0,
                          1'b0));
    // setpoint falls to the minimum: backward, axis error latched
    send_sample(mk_sample(24'(1 << FAxErr), 1'b0, 1'b0, 32'sh80000000, 32'sh80000000, '0,
                          1'b0));
    // external source, positive velocity: forward hard limit
    send_sample(mk_sample(24'((1 << FFwdHard) | (1 << FBwdHard)), 1'b0, 1'b1, 32'sh80000000,
                          32'sh80000000, 32'sh7fffffff, 1'b1));
    send_sample(mk_sample(24'hffffff, 1'b1, 1'b1, 32'sh7fffffff, 32'sh80000000,
                          32'sh00000001, 1'b1));
  endtask

  // Start from all flags set and drop the winner each time to walk the whole chain
  task automatic test_priority_chain();
    logic [FlagWidth-1:0] f;
    f = '1;
    send_sample(mk_sample(f, 1'b0, 1'b0, $urandom, $urandom, $urandom, 1'b1));
    for (int k = 0; k < 24; k++) begin
      f[PrioBits[k]] = 1'b0;
      send_sample(mk_sample(f, 1'($urandom), 1'($urandom), $urandom, $urandom, $urandom,
                            1'b1));
    end
  endtask

  task automatic test_random_motion(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) begin
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
      end
      if (i == n / 2) drain_results();
      if ($urandom_range(0, 9) == 0) send_sample(noise_sample());
      else send_sample(motion_sample());
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_direction_latch();
    test_priority_chain();
    test_random_motion(NumRandom);
    drain_results();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
